// ===== sv/plotter_command_line_parser_macros.svh =====
// Assertion macros shared by the parser modules.
`ifndef PLOTTER_COMMAND_LINE_PARSER_MACROS_SVH
`define PLOTTER_COMMAND_LINE_PARSER_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge outside reset.
`define PCP_ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("parser check failed: condition does not hold");

// Check a consequence in the same cycle as its cause.
`define PCP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser check failed: same-cycle consequence");

// Check a consequence in the cycle after its cause.
`define PCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser check failed: next-cycle consequence");

`else

`define PCP_ASSERT_HOLDS(label, clk, rst, prop)
`define PCP_ASSERT_SAME(label, clk, rst, ante, cons)
`define PCP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/pcp_pkg.sv =====
package pcp_pkg;

  // Command codes
  localparam logic [2:0] CMD_G00 = 3'd0;
  localparam logic [2:0] CMD_G01 = 3'd1;
  localparam logic [2:0] CMD_G90 = 3'd2;
  localparam logic [2:0] CMD_G91 = 3'd3;
  localparam logic [2:0] CMD_G28 = 3'd4;

  // Axis selected by a token
  localparam logic [1:0] AXIS_NONE = 2'd0;
  localparam logic [1:0] AXIS_X    = 2'd1;
  localparam logic [1:0] AXIS_Y    = 2'd2;
  localparam logic [1:0] AXIS_Z    = 2'd3;

  localparam int MAG_W = 17;
  localparam int POS_W = 16;

  // Magnitude ceiling: one past the largest positive value
  localparam logic [MAG_W-1:0] MAG_LIMIT = 17'd32768;
  localparam logic [POS_W-1:0] POS_MAX   = 16'd32767;
  localparam logic [POS_W-1:0] Z_HOME    = 16'd2;

  // One classified request from the front end to the back end
  typedef struct packed {
    logic             apply;    // a token to act on was closed
    logic             emit;     // last byte: deliver a result
    logic             cmd_hit;  // token matched a G command
    logic [2:0]       cmd;
    logic             home;     // command also homes the axes
    logic [1:0]       axis;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } pcp_event_t;

endpackage

// ===== sv/pcp_front.sv =====
`include "plotter_command_line_parser_macros.svh"

module pcp_front #(
  parameter int MAX_TOKENS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_in,
  input  logic               last,
  input  logic               queue_full,
  output logic               ev_push,
  output pcp_pkg::pcp_event_t ev
);
  import pcp_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_YU    = 8'h59;
  localparam logic [7:0] CH_YL    = 8'h79;
  localparam logic [7:0] CH_ZU    = 8'h5A;
  localparam logic [7:0] CH_ZL    = 8'h7A;
  localparam logic [2:0] TOK_SAT  = 3'd7;

  typedef enum logic [1:0] {
    PH_SPACE  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Per-line and per-token state
  logic [2:0]       token_count;
  logic [1:0]       char_pos;
  logic [7:0]       prefix [3];
  logic [1:0]       axis_target;
  phase_t           number_phase;
  logic             negative_flag;
  logic [MAG_W-1:0] accumulator;
  logic             line_ended;

  // Token state after taking an ordinary character
  logic [1:0]       char_pos_next;
  logic [7:0]       prefix_next [3];
  logic [1:0]       axis_next;
  phase_t           phase_next;
  logic             neg_next;
  logic [MAG_W-1:0] acc_next;

  // Token state that a close acts on
  logic [1:0]       src_pos;
  logic [7:0]       src_p0;
  logic [7:0]       src_p1;
  logic [7:0]       src_p2;

  logic             accept;
  logic             is_sep;
  logic             is_digit;
  logic             is_space;
  logic             is_sign;
  logic             use_next;
  logic             closing;
  logic [3:0]       digit_val;
  logic [19:0]      acc_x10;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  // Classify the byte
  assign is_sep    = (byte_in == CH_NUL) || (byte_in == CH_COLON);
  assign is_digit  = (byte_in >= CH_0) && (byte_in <= CH_9);
  assign is_space  = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
  assign is_sign   = (byte_in == CH_PLUS) || (byte_in == CH_MINUS);
  assign digit_val = byte_in[3:0];
  assign acc_x10   = {accumulator, 3'b000} + {2'b00, accumulator, 1'b0} + {16'd0, digit_val};

  // Advance the open token by one ordinary character
  always_comb begin
    char_pos_next  = char_pos;
    prefix_next[0] = prefix[0];
    prefix_next[1] = prefix[1];
    prefix_next[2] = prefix[2];
    axis_next      = axis_target;
    phase_next     = number_phase;
    neg_next       = negative_flag;
    acc_next       = accumulator;
    if (char_pos == 2'd0) begin
      if ((byte_in == CH_XU) || (byte_in == CH_XL)) begin
        axis_next = AXIS_X;
      end else if ((byte_in == CH_YU) || (byte_in == CH_YL)) begin
        axis_next = AXIS_Y;
      end else if ((byte_in == CH_ZU) || (byte_in == CH_ZL)) begin
        axis_next = AXIS_Z;
      end else begin
        axis_next = AXIS_NONE;
      end
    end else if (axis_target != AXIS_NONE && number_phase != PH_DONE) begin
      priority if (number_phase == PH_SPACE && is_space) begin
        phase_next = PH_SPACE;
      end else if (number_phase == PH_SPACE && is_sign) begin
        neg_next   = (byte_in == CH_MINUS);
        phase_next = PH_SIGN;
      end else if (is_digit) begin
        acc_next   = (acc_x10 > {3'b000, MAG_LIMIT}) ? MAG_LIMIT : acc_x10[MAG_W-1:0];
        phase_next = PH_DIGITS;
      end else begin
        phase_next = PH_DONE;
      end
    end
    if (char_pos != 2'd3) begin
      prefix_next[char_pos] = byte_in;
      char_pos_next         = char_pos + 2'd1;
    end
  end

  // Pick the token that closes on this byte
  assign use_next = !line_ended && !is_sep;
  assign src_pos  = use_next ? char_pos_next  : char_pos;
  assign src_p0   = use_next ? prefix_next[0] : prefix[0];
  assign src_p1   = use_next ? prefix_next[1] : prefix[1];
  assign src_p2   = use_next ? prefix_next[2] : prefix[2];
  assign closing  = ((!line_ended && is_sep) || last) && (src_pos != 2'd0);

  // Build the request
  always_comb begin
    ev         = '0;
    ev.apply   = closing && (token_count < 3'(MAX_TOKENS));
    ev.emit    = last;
    ev.axis    = use_next ? axis_next : axis_target;
    ev.neg     = use_next ? neg_next  : negative_flag;
    ev.mag     = use_next ? acc_next  : accumulator;
    if (src_pos == 2'd3 && src_p0 == CH_G) begin
      priority if (src_p1 == CH_0 && src_p2 == CH_0) begin
        ev.cmd_hit = 1'b1;
        ev.cmd     = CMD_G00;
        ev.home    = 1'b1;
      end else if (src_p1 == CH_0 && src_p2 == CH_1) begin
        ev.cmd_hit = 1'b1;
        ev.cmd     = CMD_G01;
      end else if (src_p1 == CH_9 && src_p2 == CH_0) begin
        ev.cmd_hit = 1'b1;
        ev.cmd     = CMD_G90;
      end else if (src_p1 == CH_9 && src_p2 == CH_1) begin
        ev.cmd_hit = 1'b1;
        ev.cmd     = CMD_G91;
        ev.home    = 1'b1;
      end else if (src_p1 == CH_2 && src_p2 == CH_8) begin
        ev.cmd_hit = 1'b1;
        ev.cmd     = CMD_G28;
      end else begin
        ev.cmd_hit = 1'b0;
      end
    end
  end

  assign ev_push = accept && (ev.apply || ev.emit);

  // Hold line state; clear on each last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      token_count   <= 3'd0;
      char_pos      <= 2'd0;
      prefix[0]     <= 8'd0;
      prefix[1]     <= 8'd0;
      prefix[2]     <= 8'd0;
      axis_target   <= AXIS_NONE;
      number_phase  <= PH_SPACE;
      negative_flag <= 1'b0;
      accumulator   <= '0;
      line_ended    <= 1'b0;
    end else if (accept) begin
      if (last || (!line_ended && is_sep)) begin
        char_pos      <= 2'd0;
        prefix[0]     <= 8'd0;
        prefix[1]     <= 8'd0;
        prefix[2]     <= 8'd0;
        axis_target   <= AXIS_NONE;
        number_phase  <= PH_SPACE;
        negative_flag <= 1'b0;
        accumulator   <= '0;
      end
      if (last) begin
        token_count <= 3'd0;
        line_ended  <= 1'b0;
      end else if (!line_ended && is_sep) begin
        if (char_pos != 2'd0 && token_count != TOK_SAT) begin
          token_count <= token_count + 3'd1;
        end
        if (byte_in == CH_NUL) begin
          line_ended <= 1'b1;
        end
      end else if (!line_ended) begin
        char_pos      <= char_pos_next;
        prefix[0]     <= prefix_next[0];
        prefix[1]     <= prefix_next[1];
        prefix[2]     <= prefix_next[2];
        axis_target   <= axis_next;
        number_phase  <= phase_next;
        negative_flag <= neg_next;
        accumulator   <= acc_next;
      end
    end
  end

  `PCP_ASSERT_NEXT(a_line_stays_ended, clk, rst, line_ended && !(accept && last), line_ended)
  `PCP_ASSERT_SAME(a_ended_no_token, clk, rst, line_ended, char_pos == 2'd0)

endmodule

// ===== sv/pcp_queue.sv =====
`include "plotter_command_line_parser_macros.svh"

module pcp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pcp_pkg::pcp_event_t push_data,
  output logic                full,
  input  logic                pop,
  output pcp_pkg::pcp_event_t pop_data,
  output logic                not_empty
);
  import pcp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  pcp_event_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  // Store request payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PCP_ASSERT_HOLDS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `PCP_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

// ===== sv/pcp_back.sv =====
`include "plotter_command_line_parser_macros.svh"

module pcp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ev_valid,
  input  pcp_pkg::pcp_event_t     ev,
  output logic                    ev_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              command,
  output logic signed [15:0]      x_pos,
  output logic signed [15:0]      y_pos,
  output logic signed [15:0]      z_pos
);
  import pcp_pkg::*;

  logic [2:0]       cmd_reg;
  logic [POS_W-1:0] x_reg;
  logic [POS_W-1:0] y_reg;
  logic [POS_W-1:0] z_reg;

  logic [2:0]       cmd_next;
  logic [POS_W-1:0] x_next;
  logic [POS_W-1:0] y_next;
  logic [POS_W-1:0] z_next;
  logic [POS_W-1:0] value;
  logic [MAG_W-1:0] neg_mag;
  logic [MAG_W-1:0] neg_word;

  // Saturate the parsed magnitude into a 16-bit value
  assign neg_mag  = (ev.mag > MAG_LIMIT) ? MAG_LIMIT : ev.mag;
  assign neg_word = {1'b1, {(MAG_W-1){1'b0}}} - neg_mag;
  assign value    = ev.neg ? neg_word[POS_W-1:0]
                  : ((ev.mag > {1'b0, POS_MAX}) ? POS_MAX : ev.mag[POS_W-1:0]);

  // Apply a closed token to the held values
  always_comb begin
    cmd_next = cmd_reg;
    x_next   = x_reg;
    y_next   = y_reg;
    z_next   = z_reg;
    if (ev.apply) begin
      if (ev.cmd_hit) begin
        cmd_next = ev.cmd;
      end
      if (ev.home) begin
        x_next = '0;
        y_next = '0;
        z_next = Z_HOME;
      end
      unique case (ev.axis)
        AXIS_X:    x_next = value;
        AXIS_Y:    y_next = value;
        AXIS_Z:    z_next = value;
        default:   cmd_next = cmd_next;
      endcase
    end
  end

  // Drain unless a result would overwrite a waiting one
  assign ev_pop = ev_valid && (!ev.emit || !out_valid || !out_stall);

  // Hold axis registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_reg <= CMD_G00;
      x_reg   <= '0;
      y_reg   <= '0;
      z_reg   <= Z_HOME;
    end else if (ev_pop) begin
      cmd_reg <= cmd_next;
      x_reg   <= x_next;
      y_reg   <= y_next;
      z_reg   <= z_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ev_pop && ev.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop && ev.emit) begin
      command <= cmd_next;
      x_pos   <= x_next;
      y_pos   <= y_next;
      z_pos   <= z_next;
    end
  end

  `PCP_ASSERT_HOLDS(a_cmd_range, clk, rst, cmd_reg <= CMD_G28)
  `PCP_ASSERT_NEXT(a_emit_shows, clk, rst, ev_pop && ev.emit, out_valid)

endmodule

// ===== sv/plotter_command_line_parser.sv =====
// Plotter command line parser. Bytes of a command line enter on byte_in with
// last set on the final byte; the line is split at colons, the first
// MAX_TOKENS tokens set the G command (G00, G01, G90, G91, G28) and the X, Y
// and Z values, and one result with the held command and axes is given per
// line. The block takes one byte every cycle unless the queue is full: the
// front end classifies each byte combinationally and hands closed tokens to
// the back end through a QUEUE_DEPTH-entry queue, and the back end applies
// one request per cycle unless its result would overwrite a stalled one. The
// last byte's request is queued, popped and registered into out_valid and
// the outputs by the back end; in_stall rises only when the queue is full.
module plotter_command_line_parser #(
  parameter int MAX_TOKENS  = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_in,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         command,
  output logic signed [15:0] x_pos,
  output logic signed [15:0] y_pos,
  output logic signed [15:0] z_pos
);
  import pcp_pkg::*;

  pcp_event_t push_data;
  pcp_event_t pop_data;
  logic       push;
  logic       pop;
  logic       full;
  logic       not_empty;

  pcp_front #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .last       (last),
    .queue_full (full),
    .ev_push    (push),
    .ev         (push_data)
  );

  pcp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  pcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (not_empty),
    .ev        (pop_data),
    .ev_pop    (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .command   (command),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .z_pos     (z_pos)
  );

endmodule
